>>> design/mpq_pkg.sv
// Shared types and codes for the min priority queue with lazy deletion.
package mpq_pkg;

	// Operation codes carried in the func field
	typedef enum logic [1:0] {
		FUNC_INSERT = 2'd0,
		FUNC_ERASE  = 2'd1,
		FUNC_TOP    = 2'd2,
		FUNC_POP    = 2'd3
	} func_t;

	// Result status codes
	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_EMPTY   = 2'd1,
		ST_PENDING = 2'd2,
		ST_FULL    = 2'd3
	} status_t;

	localparam int unsigned VALUE_W = 32;

	// Signed compare of two raw value words
	function automatic logic val_lt(input logic [VALUE_W-1:0] a, input logic [VALUE_W-1:0] b);
		val_lt = $signed(a) < $signed(b);
	endfunction

endpackage

>>> design/mpq_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
module mpq_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> design/min_priority_queue_lazy_delete.sv
// Min priority queue with lazy deletion: two unordered stores and a scanning sequencer.
//
// Usage:
//   s_axis: one operation per transfer. tuser[1:0] = func (0 insert, 1 erase,
//   2 top, 3 pop), tdata[31:0] = value (signed, used by insert and erase).
//   m_axis: one result per operation. tdata[31:0] = result_value (signed),
//   tuser[1:0] = status (0 ok, 1 empty, 2 pending without live, 3 full).
// Insert and erase: result is valid the cycle after the input transfer.
// Top and pop find each store minimum by a linear scan through its RAM read
// port, one entry a cycle. Each compare round runs decide, scan and compare;
// a matched round then adds count update, read of the last entries and move
// into the holes. After a mismatch a live-only scan follows, and pop adds
// the same move. With no pending values a top or pop runs one live-only
// round, plus the move for pop.
// Throughput is one operation at a time: input is refused while the sequencer
// is busy or a result waits in the output register, and can be taken again
// the cycle after that result's transfer.
// Reset clears both fill counts and the sequencer; RAM contents need no
// clearing since only entries below each fill count are ever used.
// A stalled receiver holds the result; input is refused until it is taken.
module min_priority_queue_lazy_delete #(
	parameter int unsigned CAPACITY = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,  // value[31:0]
	input  logic [1:0]  s_axis_tuser,  // func[1:0]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,  // result_value[31:0]
	output logic [1:0]  m_axis_tuser   // status[1:0]
);

	localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int unsigned CW = $clog2(CAPACITY + 1);
	localparam int unsigned VW = mpq_pkg::VALUE_W;

	typedef enum logic [7:0] {
		S_IDLE  = 8'b0000_0001,
		S_SCAN  = 8'b0000_0010,
		S_LAST  = 8'b0000_0100,
		S_DEC   = 8'b0000_1000,
		S_RDL   = 8'b0001_0000,
		S_MOVE  = 8'b0010_0000,
		S_OUT   = 8'b0100_0000,
		S_FINAL = 8'b1000_0000
	} state_t;

	state_t state_q;

	logic [CW-1:0] lcnt_q, pcnt_q;
	logic [1:0]    func_q;
	logic          final_q;  // scanning live only, for the reported minimum
	logic [CW-1:0] idx_q;    // current read address being issued
	logic          rv_q;     // a read was issued last cycle
	logic [AW-1:0] ridx_q;   // address of the data now on rdata
	logic [VW-1:0] lmin_q, pmin_q;
	logic [AW-1:0] lmi_q, pmi_q;
	logic          lhas_q, phas_q;
	logic [1:0]    mv_q;     // which stores need a move: bit0 live, bit1 pending

	// Output register
	logic          ov_q;
	logic [VW-1:0] ores_q;
	logic [1:0]    ost_q;

	// RAM ports
	logic          l_we, p_we;
	logic [AW-1:0] l_wa, p_wa, l_ra, p_ra;
	logic [VW-1:0] l_wd, p_wd, l_rd, p_rd;

	mpq_ram #(.WIDTH(VW), .DEPTH(CAPACITY)) u_live (
		.clk(clk), .we(l_we), .waddr(l_wa), .wdata(l_wd), .raddr(l_ra), .rdata(l_rd)
	);
	mpq_ram #(.WIDTH(VW), .DEPTH(CAPACITY)) u_pend (
		.clk(clk), .we(p_we), .waddr(p_wa), .wdata(p_wd), .raddr(p_ra), .rdata(p_rd)
	);

	logic [1:0]    in_func;
	logic [VW-1:0] in_val;
	logic          acc;
	assign in_func = s_axis_tuser;
	assign in_val  = s_axis_tdata;
	assign s_axis_tready = (state_q == S_IDLE) && !ov_q;
	assign acc = s_axis_tvalid && s_axis_tready;

	assign m_axis_tvalid = ov_q;
	assign m_axis_tdata  = ores_q;
	assign m_axis_tuser  = ost_q;

	logic l_full, p_full;
	assign l_full = (lcnt_q == CW'(CAPACITY));
	assign p_full = (pcnt_q == CW'(CAPACITY));

	logic [CW-1:0] scan_n;
	assign scan_n = (final_q || pcnt_q < lcnt_q) ? lcnt_q : pcnt_q;

	// RAM control
	always_comb begin
		l_we = 1'b0;
		p_we = 1'b0;
		l_wa = lcnt_q[AW-1:0];
		p_wa = pcnt_q[AW-1:0];
		l_wd = in_val;
		p_wd = in_val;
		l_ra = idx_q[AW-1:0];
		p_ra = idx_q[AW-1:0];
		if (acc && in_func == mpq_pkg::FUNC_INSERT && !l_full) begin
			l_we = 1'b1;
		end
		if (acc && in_func == mpq_pkg::FUNC_ERASE && !p_full) begin
			p_we = 1'b1;
		end
		// read the last entries, then write them into the holes
		if (state_q == S_RDL) begin
			l_ra = lcnt_q[AW-1:0];
			p_ra = pcnt_q[AW-1:0];
		end
		if (state_q == S_MOVE) begin
			l_we = mv_q[0];
			l_wa = lmi_q;
			l_wd = l_rd;
			p_we = mv_q[1];
			p_wa = pmi_q;
			p_wd = p_rd;
		end
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			lcnt_q  <= '0;
			pcnt_q  <= '0;
			ov_q    <= 1'b0;
			ores_q  <= '0;
			ost_q   <= mpq_pkg::ST_OK;
			func_q  <= mpq_pkg::FUNC_INSERT;
			rv_q    <= 1'b0;
			ridx_q  <= '0;
			final_q <= 1'b0;
			idx_q   <= '0;
			mv_q    <= '0;
			lmin_q  <= '0;
			pmin_q  <= '0;
			lmi_q   <= '0;
			pmi_q   <= '0;
			lhas_q  <= 1'b0;
			phas_q  <= 1'b0;
		end else begin
			if (ov_q && m_axis_tready) begin
				ov_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (acc) begin
						func_q <= in_func;
						ores_q <= '0;
						case (in_func)
							mpq_pkg::FUNC_INSERT: begin
								ov_q  <= 1'b1;
								ost_q <= l_full ? mpq_pkg::ST_FULL : mpq_pkg::ST_OK;
								if (!l_full) lcnt_q <= lcnt_q + CW'(1);
							end
							mpq_pkg::FUNC_ERASE: begin
								ov_q  <= 1'b1;
								ost_q <= p_full ? mpq_pkg::ST_FULL : mpq_pkg::ST_OK;
								if (!p_full) pcnt_q <= pcnt_q + CW'(1);
							end
							default: begin
								ost_q   <= mpq_pkg::ST_OK;
								state_q <= S_OUT;
							end
						endcase
					end
				end
				// decide: cancel round, final live scan, or an empty report
				S_OUT: begin
					idx_q  <= '0;
					rv_q   <= 1'b0;
					lhas_q <= 1'b0;
					phas_q <= 1'b0;
					if (lcnt_q == '0) begin
						ost_q   <= (pcnt_q != '0) ? mpq_pkg::ST_PENDING : mpq_pkg::ST_EMPTY;
						ov_q    <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						final_q <= (pcnt_q == '0);
						state_q <= S_SCAN;
					end
				end
				// issue reads and fold returned data into running minima
				S_SCAN: begin
					rv_q   <= (idx_q < scan_n);
					ridx_q <= idx_q[AW-1:0];
					if (idx_q < scan_n) begin
						idx_q <= idx_q + CW'(1);
					end else if (!rv_q) begin
						state_q <= S_LAST;
					end
					if (rv_q) begin
						if (CW'(ridx_q) < lcnt_q &&
						    (!lhas_q || mpq_pkg::val_lt(l_rd, lmin_q))) begin
							lmin_q <= l_rd;
							lmi_q  <= ridx_q;
							lhas_q <= 1'b1;
						end
						if (!final_q && CW'(ridx_q) < pcnt_q &&
						    (!phas_q || mpq_pkg::val_lt(p_rd, pmin_q))) begin
							pmin_q <= p_rd;
							pmi_q  <= ridx_q;
							phas_q <= 1'b1;
						end
					end
				end
				// compare minima: cancel, rescan live only, or report (pop moves first)
				S_LAST: begin
					if (final_q) begin
						ores_q <= lmin_q;
						if (func_q == mpq_pkg::FUNC_POP) begin
							mv_q    <= 2'b01;
							state_q <= S_DEC;
						end else begin
							ov_q    <= 1'b1;
							state_q <= S_IDLE;
						end
					end else if (lmin_q == pmin_q) begin
						mv_q    <= 2'b11;
						state_q <= S_DEC;
					end else begin
						final_q <= 1'b1;
						idx_q   <= '0;
						lhas_q  <= 1'b0;
						state_q <= S_SCAN;
					end
				end
				S_DEC: begin
					if (mv_q[0]) lcnt_q <= lcnt_q - CW'(1);
					if (mv_q[1]) pcnt_q <= pcnt_q - CW'(1);
					state_q <= S_RDL;
				end
				S_RDL: begin
					state_q <= S_MOVE;
				end
				// write last entries into the holes, then continue or report
				S_MOVE: begin
					if (final_q) begin
						ov_q    <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						state_q <= S_OUT;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

`ifndef SYNTHESIS
	// Fill counts never pass the capacity
	a_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		lcnt_q <= CW'(CAPACITY) && pcnt_q <= CW'(CAPACITY))
		else $error("fill count overflow");
	// Input is only taken in idle with an empty output register
	a_acc: assert property (@(posedge clk) disable iff (!arst_n)
		acc |-> (state_q == S_IDLE && !ov_q))
		else $error("accept while busy");
	// A successful pop lowers the live count by one
	a_pop: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DEC && mv_q == 2'b01) |=> lcnt_q == $past(lcnt_q) - CW'(1))
		else $error("pop count");
	// Status ok is never reported after a top or pop on an empty live store
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_OUT && lcnt_q == '0) |=> (ov_q && ost_q != mpq_pkg::ST_OK))
		else $error("empty status");
`endif

endmodule
